### src/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent assertion, clocked on clk_i, off during reset.
`define ASRT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Same, but with no reset gating.
`define ASRT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`endif

### src/scp_pkg.sv
// Package for the spirograph curve point unit: widths, constants, tables, types.
// No dependencies.
package scp_pkg;
  localparam int unsigned CordicStages = 16;
  localparam int unsigned NumRegs = 8;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned DivSteps = 49;

  localparam logic signed [35:0] TwoPiQ32 = 36'sd26986075409;
  localparam logic signed [35:0] PiQ32 = 36'sd13493037705;
  localparam logic signed [35:0] HalfPiQ32 = 36'sd6746518852;
  localparam logic signed [33:0] GainQ30 = 34'sd652032874;

  typedef enum logic [RegIdxW-1:0] {
    REG_RADIUS_A = 3'd0,
    REG_RADIUS_B = 3'd1,
    REG_OFFSET_D = 3'd2,
    REG_PEN_X = 3'd3,
    REG_PEN_Y = 3'd4,
    REG_ANGLE_LOW = 3'd5,
    REG_ANGLE_HIGH = 3'd6,
    REG_WEIGHT = 3'd7
  } reg_idx_e;

  // CORDIC state carried from cell to cell
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic neg;
  } rot_t;

  function automatic logic signed [33:0] atan_q30(input int unsigned idx);
    logic signed [33:0] v;
    case (idx & 31)
      0: v = 34'sd843314857;
      1: v = 34'sd497837830;
      2: v = 34'sd263043837;
      3: v = 34'sd133525159;
      4: v = 34'sd67021687;
      5: v = 34'sd33543516;
      6: v = 34'sd16775851;
      7: v = 34'sd8388437;
      8: v = 34'sd4194283;
      9: v = 34'sd2097149;
      31: v = 34'sd0;
      default: v = 34'sd1 <<< (30 - (idx & 31));
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction
endpackage

### src/scp_div_cell.sv
// One restoring-division step for the ratio (a+b)*2^16 / b.
// Depends on scp_pkg.
module scp_div_cell (
  input  logic        clk_i,
  input  logic [48:0] rem_i,
  input  logic [48:0] quo_i,
  input  logic [48:0] dvs_i,
  output logic [48:0] rem_o,
  output logic [48:0] quo_o,
  output logic [48:0] dvs_o
);
  import scp_pkg::*;
  logic [49:0] trial;
  logic [48:0] rem_d, quo_d, rem_q, quo_q, dvs_q;
  // shift in next dividend bit, try subtract
  always_comb begin
    trial = {rem_i, quo_i[48]} - {1'b0, dvs_i};
    if (!trial[49]) begin
      rem_d = trial[48:0];
      quo_d = {quo_i[47:0], 1'b1};
    end else begin
      rem_d = {rem_i[47:0], quo_i[48]};
      quo_d = {quo_i[47:0], 1'b0};
    end
  end
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_i;
  end
  assign rem_o = rem_q;
  assign quo_o = quo_q;
  assign dvs_o = dvs_q;
endmodule

### src/scp_cordic_cell.sv
// One rotation-mode CORDIC cell with a fixed shift.
// Depends on scp_pkg.
module scp_cordic_cell (
  input  logic  clk_i,
  input  logic  en_i,
  input  logic [4:0] shift_i,
  input  scp_pkg::rot_t rot_i,
  output scp_pkg::rot_t rot_o
);
  import scp_pkg::*;
  rot_t rot_d, rot_q;
  logic signed [33:0] dx, dy, at;
  always_comb begin
    dx = rot_i.y >>> shift_i;
    dy = rot_i.x >>> shift_i;
    at = atan_q30(32'(shift_i));
    rot_d = rot_i;
    if (!rot_i.z[33]) begin
      rot_d.x = rot_i.x - dx;
      rot_d.y = rot_i.y + dy;
      rot_d.z = rot_i.z - at;
    end else begin
      rot_d.x = rot_i.x + dx;
      rot_d.y = rot_i.y - dy;
      rot_d.z = rot_i.z + at;
    end
  end
  // hold while the pipe is frozen
  always_ff @(posedge clk_i) if (en_i) rot_q <= rot_d;
  assign rot_o = rot_q;
endmodule

### src/spirograph_curve_point_unit.sv
// Spirograph curve point unit: fully pipelined, one beat in per clock unless stalled.
// An accepted beat waits in the input delay line while the ratio divider chain
// settles, then passes the angle stage, the Q32.32 product stage, the 2pi reduction
// stages, the fold stage, the CORDIC cells and the sum stages.
// A beat is accepted each cycle unless a finished result is held by out_stall_i; that
// stall freezes the whole pipe, and the output registers keep the waiting result.
// The ratio settles through the divider chain after a register write, before any later beat needs it.
// Depends on scp_pkg, scp_div_cell and scp_cordic_cell.
module spirograph_curve_point_unit (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic [15:0] angle_fraction_i,
  input  logic signed [31:0] jitter_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  input  logic signed [31:0] affine_z_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic signed [31:0] new_x_o,
  output logic signed [31:0] new_y_o,
  output logic signed [31:0] new_z_o,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [scp_pkg::RegIdxW-1:0] cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import scp_pkg::*;
  localparam int unsigned Lat = DivSteps + CordicStages + 8;
  localparam logic [29:0] RecipTwoPi = 30'd683565275;

  logic signed [31:0] ra_q, rb_q, rd_q, c1_q, c2_q, lo_q, hi_q, w_q;
  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ra_q <= 32'sd196608; rb_q <= 32'sd131072; rd_q <= '0; c1_q <= '0;
      c2_q <= '0; lo_q <= -32'sd65536; hi_q <= 32'sd65536; w_q <= 32'sd65536;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_RADIUS_A: ra_q <= cfg_data_i;
        REG_RADIUS_B: rb_q <= cfg_data_i;
        REG_OFFSET_D: rd_q <= cfg_data_i;
        REG_PEN_X: c1_q <= cfg_data_i;
        REG_PEN_Y: c2_q <= cfg_data_i;
        REG_ANGLE_LOW: lo_q <= cfg_data_i;
        REG_ANGLE_HIGH: hi_q <= cfg_data_i;
        REG_WEIGHT: w_q <= cfg_data_i;
        default: ;
      endcase
    end
  end
  assign cfg_ready_o = 1'b1;

  // advance whole pipe unless output is held
  logic adv;
  logic [Lat-1:0] vld_q;
  assign adv = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[Lat-2:0], in_valid_i};
  end
  assign out_valid_o = vld_q[Lat-1];

  // The user must keep config static while items are in flight (the block does not
  // enforce it), so the ratio k is computed by a free-running divider chain on the
  // registers; it is only consumed after the chain has settled past any write.
  logic signed [32:0] ab;
  logic [48:0] num_mag, dvs_mag;
  assign ab = 33'(ra_q) + 33'(rb_q);
  assign num_mag = ab[32] ? 49'(-{ab, 16'd0}) : 49'({ab, 16'd0});
  assign dvs_mag = rb_q[31] ? 49'(-33'(rb_q)) : 49'(rb_q);
  logic [48:0] rem_w [DivSteps+1];
  logic [48:0] quo_w [DivSteps+1];
  logic [48:0] dvs_w [DivSteps+1];
  assign rem_w[0] = '0;
  assign quo_w[0] = num_mag;
  assign dvs_w[0] = dvs_mag;
  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    scp_div_cell u_cell (
      .clk_i, .rem_i(rem_w[g]), .quo_i(quo_w[g]), .dvs_i(dvs_w[g]),
      .rem_o(rem_w[g+1]), .quo_o(quo_w[g+1]), .dvs_o(dvs_w[g+1])
    );
  end
  logic signed [31:0] k_q;
  logic signed [50:0] kq;
  always_comb
    kq = ((ab[32] ^ rb_q[31]) ? -$signed({2'b0, quo_w[DivSteps]})
                              : $signed({2'b0, quo_w[DivSteps]}));
  always_ff @(posedge clk_i) begin
    if (rb_q == 0) k_q <= ab[32] ? 32'sh80000000 : (ab == 0 ? 32'sd0 : 32'sh7fffffff);
    else k_q <= sat32(66'(kq));
  end

  // input delay line, tapped for the angle fraction, the jitter and the point
  localparam int unsigned PW = 16 + 5*32;
  logic [PW-1:0] dly_q [Lat-1];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dly_q[0] <= {angle_fraction_i, jitter_i, point_x_i, point_y_i, point_z_i,
                   affine_z_i};
      for (int i = 1; i < Lat-1; i++) dly_q[i] <= dly_q[i-1];
    end
  end

  // stage A: t = lo + ((hi-lo)*f >> 16)
  logic signed [31:0] t_q;
  logic signed [50:0] tp;
  always_comb tp = (51'(hi_q) - 51'(lo_q)) * $signed({35'd0, dly_q[DivSteps][PW-1 -: 16]});
  always_ff @(posedge clk_i)
    if (adv) t_q <= 32'(51'(lo_q) + (tp >>> 16));
  // stage B: angles in Q32.32
  logic signed [63:0] a1_q, a2_q;
  always_ff @(posedge clk_i)
    if (adv) begin
      a1_q <= 64'(t_q) <<< 16;
      a2_q <= 64'(k_q) * 64'(t_q);
    end
  // stage C1: magnitude and quotient estimate by reciprocal, at most two low
  function automatic logic [63:0] mag64(input logic signed [63:0] a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction
  function automatic logic [33:0] quo2pi(input logic [63:0] m);
    logic [63:0] p;
    p = 64'(m[63:30]) * 64'(RecipTwoPi);
    return 34'(p >> 34);
  endfunction
  logic [63:0] m1_q, m2_q;
  logic [33:0] q1_q, q2_q;
  logic s1_q, s2_q;
  always_ff @(posedge clk_i)
    if (adv) begin
      m1_q <= mag64(a1_q);
      m2_q <= mag64(a2_q);
      q1_q <= quo2pi(mag64(a1_q));
      q2_q <= quo2pi(mag64(a2_q));
      s1_q <= a1_q[63];
      s2_q <= a2_q[63];
    end
  // stage C2: remainder by 2pi with up to two corrections, sign of the angle
  logic signed [35:0] r1_q, r2_q;
  function automatic logic signed [35:0] rem2pi(input logic [63:0] m, input logic neg,
                                                input logic [33:0] q);
    logic [63:0] r;
    r = m - 64'(q) * 64'(TwoPiQ32);
    if (r >= 64'(TwoPiQ32)) r = r - 64'(TwoPiQ32);
    if (r >= 64'(TwoPiQ32)) r = r - 64'(TwoPiQ32);
    return neg ? -$signed(36'(r)) : $signed(36'(r));
  endfunction
  always_ff @(posedge clk_i)
    if (adv) begin
      r1_q <= rem2pi(m1_q, s1_q, q1_q);
      r2_q <= rem2pi(m2_q, s2_q, q2_q);
    end
  // stage D: fold into [-pi/2, pi/2]
  function automatic rot_t fold(input logic signed [35:0] r0);
    logic signed [35:0] r;
    rot_t o;
    r = r0;
    o.neg = 1'b0;
    if (r > PiQ32) r = r - TwoPiQ32;
    if (r < -PiQ32) r = r + TwoPiQ32;
    if (r > HalfPiQ32) begin r = r - PiQ32; o.neg = 1'b1; end
    else if (r < -HalfPiQ32) begin r = r + PiQ32; o.neg = 1'b1; end
    o.x = GainQ30;
    o.y = '0;
    o.z = 34'(r >>> 2);
    return o;
  endfunction
  rot_t f1_q, f2_q;
  always_ff @(posedge clk_i)
    if (adv) begin
      f1_q <= fold(r1_q);
      f2_q <= fold(r2_q);
    end
  // CORDIC cell rows
  rot_t c1_w [CordicStages+1];
  rot_t c2_w [CordicStages+1];
  assign c1_w[0] = f1_q;
  assign c2_w[0] = f2_q;
  for (genvar g = 0; g < CordicStages; g++) begin : g_rot
    scp_cordic_cell u_c1 (
      .clk_i, .en_i(adv), .shift_i(5'(g)), .rot_i(c1_w[g]), .rot_o(c1_w[g+1])
    );
    scp_cordic_cell u_c2 (
      .clk_i, .en_i(adv), .shift_i(5'(g)), .rot_i(c2_w[g]), .rot_o(c2_w[g+1])
    );
  end
  // final sums
  logic [31:0] jt;
  logic [PW-1:0] tl;
  assign jt = dly_q[Lat-3][159:128];
  assign tl = dly_q[Lat-2];
  logic signed [33:0] ct, st, ck, sk;
  assign ct = c1_w[CordicStages].neg ? -c1_w[CordicStages].x : c1_w[CordicStages].x;
  assign st = c1_w[CordicStages].neg ? -c1_w[CordicStages].y : c1_w[CordicStages].y;
  assign ck = c2_w[CordicStages].neg ? -c2_w[CordicStages].x : c2_w[CordicStages].x;
  assign sk = c2_w[CordicStages].neg ? -c2_w[CordicStages].y : c2_w[CordicStages].y;
  logic signed [65:0] rad, sx, sy;
  always_comb begin
    rad = 66'(ra_q) + 66'(rb_q) + 66'(rd_q);
    sx = ((rad * 66'(ct)) >>> 30) - ((66'(c1_q) * 66'(ck)) >>> 30) + 66'($signed(jt));
    sy = ((rad * 66'(st)) >>> 30) - ((66'(c2_q) * 66'(sk)) >>> 30) + 66'($signed(jt));
  end
  logic signed [31:0] sx_q, sy_q;
  logic signed [31:0] nx_q, ny_q, nz_q;
  always_ff @(posedge clk_i)
    if (adv) begin
      sx_q <= sat32(sx);
      sy_q <= sat32(sy);
      nx_q <= sat32(66'($signed(tl[127:96])) + ((66'(w_q) * 66'(sx_q)) >>> 16));
      ny_q <= sat32(66'($signed(tl[95:64])) + ((66'(w_q) * 66'(sy_q)) >>> 16));
      nz_q <= sat32(66'($signed(tl[63:32])) + ((66'(w_q) * 66'($signed(tl[31:0]))) >>> 16));
    end
  assign new_x_o = nx_q;
  assign new_y_o = ny_q;
  assign new_z_o = nz_q;
endmodule

### src/scp_checker.sv
// Port-level checker for the spirograph curve point unit, with its bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module scp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic [31:0] new_x_o
);
  `ASRT(a_stall_only_held, in_stall_o |-> out_valid_o && out_stall_i, "stall without held output")
  `ASRT(a_hold_valid, out_valid_o && out_stall_i |=> out_valid_o, "result dropped")
  `ASRT(a_hold_data, out_valid_o && out_stall_i |=> $stable(new_x_o), "result changed")
  `ASRT_ALWAYS(a_rst_empty, !rst_ni |=> !out_valid_o, "valid in reset")
endmodule

bind spirograph_curve_point_unit scp_checker u_chk (.*);

### dv/tb_spirograph_curve_point_unit.sv
// Self-checking testbench for spirograph_curve_point_unit: random and directed beats,
// a bit-exact curve point predictor, random input bursts and gaps, and random output stalls.
// Depends on scp_pkg and the RTL of the unit.
module tb_spirograph_curve_point_unit;
  import scp_pkg::*;

  localparam int Latency = DivSteps + CordicStages + 7;
  localparam int CycleLimit = 400000;
  localparam longint TwoPi = 64'sd26986075409;
  localparam longint Pi = 64'sd13493037705;
  localparam longint HalfPi = 64'sd6746518852;
  localparam longint Gain = 64'sd652032874;
  localparam longint AtanTab[32] = '{
    843314857, 497837830, 263043837, 133525159, 67021687, 33543516, 16775851, 8388437,
    4194283, 2097149, 1048576, 524288, 262144, 131072, 65536, 32768,
    16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0};

  typedef struct {
    logic [15:0] frac;
    logic signed [31:0] jit, px, py, pz, az;
  } pt_in_t;

  typedef struct {
    logic signed [31:0] x, y, z;
  } pt_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall_o;
  logic [15:0] angle_fraction = '0;
  logic signed [31:0] jitter = '0, point_x = '0, point_y = '0, point_z = '0, affine_z = '0;
  logic out_valid_o;
  logic out_stall = 1'b1;
  logic signed [31:0] new_x_o, new_y_o, new_z_o;
  logic cfg_valid = 1'b0;
  logic cfg_ready_o;
  logic [RegIdxW-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  logic signed [31:0] curve_regs[NumRegs];
  pt_in_t pending_pts[$];
  pt_out_t expected_pts[$];
  int errors = 0;
  int cycles = 0;
  int long_hold = 0;
  bit took = 1'b0;
  int burst_left = 4;
  int gap_left = 0;

  spirograph_curve_point_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall_o),
    .angle_fraction_i(angle_fraction), .jitter_i(jitter),
    .point_x_i(point_x), .point_y_i(point_y), .point_z_i(point_z), .affine_z_i(affine_z),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall),
    .new_x_o(new_x_o), .new_y_o(new_y_o), .new_z_o(new_z_o),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Q32.32 angle -> cosine/sine in Q2.30 via range reduction and CORDIC
  task automatic rotate(input longint ang, output longint c, output longint s);
    longint r, x, y, z, dx, dy;
    bit flip;
    int sh;
    r = ang % TwoPi;
    flip = 1'b0;
    x = Gain;
    y = 0;
    if (r > Pi) r -= TwoPi;
    if (r < -Pi) r += TwoPi;
    if (r > HalfPi) begin
      r -= Pi;
      flip = 1'b1;
    end else if (r < -HalfPi) begin
      r += Pi;
      flip = 1'b1;
    end
    z = r >>> 2;
    for (int i = 0; i < CordicStages; i++) begin
      sh = i & 31;
      dx = y >>> sh;
      dy = x >>> sh;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= AtanTab[sh];
      end else begin
        x += dx;
        y -= dy;
        z += AtanTab[sh];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  // Expected curve point for one input beat under the current registers
  task automatic curve_point(input pt_in_t p, output pt_out_t o);
    longint a, b, d, c1, c2, lo, hi, w, t, num, k, ct, st, ck, sk, rad, sx, sy;
    a = curve_regs[REG_RADIUS_A];
    b = curve_regs[REG_RADIUS_B];
    d = curve_regs[REG_OFFSET_D];
    c1 = curve_regs[REG_PEN_X];
    c2 = curve_regs[REG_PEN_Y];
    lo = curve_regs[REG_ANGLE_LOW];
    hi = curve_regs[REG_ANGLE_HIGH];
    w = curve_regs[REG_WEIGHT];
    t = lo + (((hi - lo) * longint'(p.frac)) >>> 16);
    num = (a + b) * 65536;
    // zero rolling radius pins the ratio to a rail or to zero
    if (b == 0) k = num > 0 ? 64'sd2147483647 : (num < 0 ? -64'sd2147483648 : 0);
    else k = clamp32(num / b);
    rotate(t * 65536, ct, st);
    rotate(k * t, ck, sk);
    rad = a + b + d;
    sx = clamp32((rad * ct >>> 30) - (c1 * ck >>> 30) + longint'(p.jit));
    sy = clamp32((rad * st >>> 30) - (c2 * sk >>> 30) + longint'(p.jit));
    o.x = 32'(clamp32(longint'(p.px) + (w * sx >>> 16)));
    o.y = 32'(clamp32(longint'(p.py) + (w * sy >>> 16)));
    o.z = 32'(clamp32(longint'(p.pz) + (w * longint'(p.az) >>> 16)));
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Input beat driver: bursts and gaps, payload held until accepted
  always @(negedge clk_i) begin
    logic nv;
    nv = in_valid;
    if (in_valid && took) begin
      nv = 1'b0;
      void'(pending_pts.pop_front());
    end
    if (!nv && rst_ni) begin
      if (gap_left > 0) gap_left--;
      else if (pending_pts.size() > 0) begin
        angle_fraction <= pending_pts[0].frac;
        jitter <= pending_pts[0].jit;
        point_x <= pending_pts[0].px;
        point_y <= pending_pts[0].py;
        point_z <= pending_pts[0].pz;
        affine_z <= pending_pts[0].az;
        nv = 1'b1;
        if (--burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
        end
      end
    end
    in_valid <= nv;
  end

  // Output stall pattern, with an occasional long hold-off
  always @(negedge clk_i) begin
    if (long_hold > 0) begin
      long_hold--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 9) < 3);
    end
  end

  // Sample accepted beats on both channels; watchdog
  always @(posedge clk_i) begin
    pt_out_t e;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      took = in_valid && !in_stall_o;
      if (took) begin
        curve_point(pending_pts[0], e);
        expected_pts.push_back(e);
      end
      if (rst_ni && out_valid_o && !out_stall) begin
        if (expected_pts.size() == 0) report("unexpected beat", new_x_o, 32'h0);
        else begin
          e = expected_pts.pop_front();
          if (new_x_o !== e.x) report("new_x", new_x_o, e.x);
          if (new_y_o !== e.y) report("new_y", new_y_o, e.y);
          if (new_z_o !== e.z) report("new_z", new_z_o, e.z);
        end
      end
    end
  end

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    curve_regs[idx] = val;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_curve(input logic [31:0] a, b, d, c1, c2, lo, hi, w);
    write_reg(REG_RADIUS_A, a);
    write_reg(REG_RADIUS_B, b);
    write_reg(REG_OFFSET_D, d);
    write_reg(REG_PEN_X, c1);
    write_reg(REG_PEN_Y, c2);
    write_reg(REG_ANGLE_LOW, lo);
    write_reg(REG_ANGLE_HIGH, hi);
    write_reg(REG_WEIGHT, w);
  endtask

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      1: return 32'(int'($urandom_range(0, 20 << 16)) - (10 << 16));
      2: return 32'(int'($urandom_range(0, 1 << 16)) - (1 << 15));
      default: return $urandom;
    endcase
  endfunction

  task automatic add_pt(input logic [15:0] f, input logic [31:0] j, x, y, z, az);
    pt_in_t p;
    p.frac = f;
    p.jit = j;
    p.px = x;
    p.py = y;
    p.pz = z;
    p.az = az;
    pending_pts.push_back(p);
  endtask

  task automatic add_random(input int n);
    for (int i = 0; i < n; i++)
      add_pt(16'($urandom), pick32(), pick32(), pick32(), pick32(), pick32());
  endtask

  // Let the pipe drain completely before touching registers
  task automatic drain();
    while (pending_pts.size() > 0 || in_valid || expected_pts.size() > 0)
      @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
  endtask

  initial begin
    curve_regs = '{32'sd196608, 32'sd131072, 0, 0, 0, -32'sd65536, 32'sd65536, 32'sd65536};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset registers: fraction and field extremes
    add_pt(16'h0000, 0, 0, 0, 0, 0);
    add_pt(16'hffff, 0, 0, 0, 0, 0);
    add_pt(16'h8000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    add_pt(16'h4000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    add_pt(16'hffff, 32'hffffffff, 32'h00010000, 32'hffff0000, 32'h55555555, 32'haaaaaaaa);
    add_pt(16'h5555, 32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555);
    add_random(40);
    drain();

    // ordinary curve, angle from -4pi to 4pi; receiver holds off so the pipe fills up
    set_curve(32'h00030000, 32'h00010000, 32'h00008000, 32'h00018000, 32'h00020000,
              32'hfff36f02, 32'h000c90fe, 32'h00010000);
    long_hold = 400;
    add_random(80);
    drain();

    // zero rolling radius with positive, negative and zero sum
    set_curve(32'h00020000, 0, 32'h00010000, 32'h00010000, 32'h00010000,
              32'hfffc0000, 32'h00040000, 32'h00008000);
    add_random(40);
    drain();
    write_reg(REG_RADIUS_A, 32'hfffd0000);
    add_random(30);
    drain();
    write_reg(REG_RADIUS_A, 0);
    add_random(30);
    drain();

    // huge ratio, reversed angle bounds, negative weight
    set_curve(32'h7fffffff, 32'h00000001, 32'h80000000, 32'h7fffffff, 32'h80000000,
              32'h00100000, 32'hfff00000, 32'hffff0000);
    add_random(40);
    drain();

    // all registers at the top rail, then all but the angle high bound at the bottom rail
    set_curve(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
              32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    add_random(40);
    drain();
    set_curve(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
              32'h80000000, 32'h7fffffff, 32'h80000000);
    add_random(40);
    drain();

    // random register sets
    for (int ph = 0; ph < 3; ph++) begin
      set_curve(pick32(), pick32(), pick32(), pick32(), pick32(), pick32(), pick32(),
                pick32());
      add_random(40);
      drain();
    end

    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

### files.f
+incdir+src
src/scp_pkg.sv
src/scp_div_cell.sv
src/scp_cordic_cell.sv
src/spirograph_curve_point_unit.sv
src/scp_checker.sv
dv/tb_spirograph_curve_point_unit.sv
